/* hw/rtl/glyph_text_layout_with_color_escapes_defines.svh */
// Assertion helpers for the glyph text layout block.
// Each macro expects clk and rst to be visible where it is used.
`ifndef GLYPH_TEXT_LAYOUT_WITH_COLOR_ESCAPES_DEFINES_SVH
`define GLYPH_TEXT_LAYOUT_WITH_COLOR_ESCAPES_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GTL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/gtl_pkg.sv */
`default_nettype none

package gtl_pkg;

  localparam int unsigned GLYPH_PIXELS_DEFAULT = 8;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_Y = 2'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 32'hFFFF_FFFF;

  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  typedef enum logic [1:0] {
    ESC_NONE   = 2'd0,
    ESC_DOLLAR = 2'd1,
    ESC_TENS   = 2'd2
  } esc_mode_t;

  typedef struct packed {
    logic [3:0]               glyph_col;
    logic [3:0]               glyph_row;
    logic signed [POS_W-1:0]  pen_x;
    logic signed [POS_W-1:0]  pen_y;
    logic [COLOR_W-1:0]       glyph_color;
    logic                     escape_error;
  } result_t;

  // Atlas cell of a character byte, as {col, row}. Lower case folds to upper
  // case; anything not in the font draws the question mark cell.
  function automatic logic [7:0] glyph_cell(input logic [7:0] code);
    logic [7:0] u;
    logic [3:0] col;
    logic [3:0] row;
    u = (code >= "a" && code <= "z") ? code - 8'd32 : code;
    col = 4'd2;
    row = 4'd11;
    if (u >= "A" && u <= "P") begin
      col = 4'(u - "A");
      row = 4'd15;
    end else if (u >= "Q" && u <= "Z") begin
      col = 4'(u - "Q");
      row = 4'd14;
    end else if (u >= "0" && u <= "9") begin
      col = 4'(u - "0");
      row = 4'd13;
    end else begin
      case (u)
        " ":  begin col = 4'd10; row = 4'd14; end
        "!":  begin col = 4'd0;  row = 4'd12; end
        "@":  begin col = 4'd1;  row = 4'd12; end
        "#":  begin col = 4'd2;  row = 4'd12; end
        "$":  begin col = 4'd3;  row = 4'd12; end
        "^":  begin col = 4'd4;  row = 4'd12; end
        "&":  begin col = 4'd5;  row = 4'd12; end
        "*":  begin col = 4'd6;  row = 4'd12; end
        "(":  begin col = 4'd7;  row = 4'd12; end
        ")":  begin col = 4'd8;  row = 4'd12; end
        "_":  begin col = 4'd9;  row = 4'd12; end
        "+":  begin col = 4'd10; row = 4'd12; end
        "-":  begin col = 4'd11; row = 4'd12; end
        "=":  begin col = 4'd12; row = 4'd12; end
        ",":  begin col = 4'd13; row = 4'd12; end
        ".":  begin col = 4'd14; row = 4'd12; end
        "/":  begin col = 4'd15; row = 4'd12; end
        "<":  begin col = 4'd0;  row = 4'd11; end
        ">":  begin col = 4'd1;  row = 4'd11; end
        "?":  begin col = 4'd2;  row = 4'd11; end
        ";":  begin col = 4'd3;  row = 4'd11; end
        "'":  begin col = 4'd4;  row = 4'd11; end
        ":":  begin col = 4'd5;  row = 4'd11; end
        "\"": begin col = 4'd6;  row = 4'd11; end
        "[":  begin col = 4'd7;  row = 4'd11; end
        "]":  begin col = 4'd8;  row = 4'd11; end
        default: begin col = 4'd2; row = 4'd11; end
      endcase
    end
    return {col, row};
  endfunction

  // Palette lookup for index tens*10 + units. Only the first five entries
  // carry a color, so only a zero tens digit can select one.
  function automatic logic [COLOR_W-1:0] palette_color(input logic [3:0] tens,
                                                       input logic [3:0] units);
    logic [COLOR_W-1:0] c;
    c = '0;
    if (tens == 4'd0) begin
      case (units)
        4'd0:    c = 32'hFFFF_FFFF;
        4'd1:    c = 32'h0000_00FF;
        4'd2:    c = 32'hFF00_00FF;
        4'd3:    c = 32'h00FF_00FF;
        4'd4:    c = 32'h0000_FFFF;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/gtl_char_if.sv */
`default_nettype none

interface gtl_char_if;
  logic                              valid;
  logic                              ready;
  logic [7:0]                        char_code;
  logic                              first_char;
  logic                              last_char;
  logic signed [gtl_pkg::POS_W-1:0]  origin_x;
  logic signed [gtl_pkg::POS_W-1:0]  origin_y;
  logic [gtl_pkg::COLOR_W-1:0]       start_color;

  modport source (
    output valid, char_code, first_char, last_char, origin_x, origin_y, start_color,
    input  ready
  );

  modport sink (
    input  valid, char_code, first_char, last_char, origin_x, origin_y, start_color,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/gtl_glyph_if.sv */
`default_nettype none

interface gtl_glyph_if;
  logic                              valid;
  logic                              ready;
  logic [3:0]                        glyph_col;
  logic [3:0]                        glyph_row;
  logic signed [gtl_pkg::POS_W-1:0]  pen_x;
  logic signed [gtl_pkg::POS_W-1:0]  pen_y;
  logic [gtl_pkg::COLOR_W-1:0]       glyph_color;
  logic                              escape_error;

  modport source (
    output valid, glyph_col, glyph_row, pen_x, pen_y, glyph_color, escape_error,
    input  ready
  );

  modport sink (
    input  valid, glyph_col, glyph_row, pen_x, pen_y, glyph_color, escape_error,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/gtl_cfg_if.sv */
`default_nettype none

interface gtl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [gtl_pkg::CFG_INDEX_W-1:0]     index;
  logic [gtl_pkg::SCALE_W-1:0]         data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/glyph_text_layout_with_color_escapes.sv */
// Channel   Modport  Direction  Payload
// chars     sink     in         char_code, first_char, last_char, origin, start_color
// glyphs    source   out        glyph cell, pen position, color, escape_error
// cfg       sink     in         register index, 16-bit scale value
//
// One character is taken per clock while chars.ready is high; a drawn character
// or an escape error is registered as a glyph record. The saturating pen add
// feeds the string state registers and the cell lookup feeds the result register.
// A two-entry output (result register plus skid register) lets a character be
// taken while a result waits; chars.ready drops only while the skid is full.
// Reset is synchronous; configuration writes are always taken.

`default_nettype none

`include "glyph_text_layout_with_color_escapes_defines.svh"

module glyph_text_layout_with_color_escapes #(
  parameter int unsigned GLYPH_PIXELS = gtl_pkg::GLYPH_PIXELS_DEFAULT
) (
  input  wire       clk,
  input  wire       rst,
  gtl_char_if.sink    chars,
  gtl_glyph_if.source glyphs,
  gtl_cfg_if.sink     cfg
);
  import gtl_pkg::*;

  localparam int unsigned STEP_W = SCALE_W + $clog2(GLYPH_PIXELS + 1);
  localparam int unsigned SUM_W  = ((STEP_W + 1 > POS_W) ? STEP_W + 1 : POS_W) + 1;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(GLYPH_PIXELS * 256);

  // Per-axis pen steps are stored as GLYPH_PIXELS times the scale, so the
  // multiply happens once per configuration write.
  logic [STEP_W-1:0] step_x;
  logic [STEP_W-1:0] step_y;

  esc_mode_t               esc_mode;
  logic [3:0]              tens;
  logic signed [POS_W-1:0] cur_x;
  logic signed [POS_W-1:0] cur_y;
  logic signed [POS_W-1:0] line_x;
  logic [COLOR_W-1:0]      color;

  esc_mode_t               esc_mode_next;
  logic [3:0]              tens_next;
  logic signed [POS_W-1:0] cur_x_next;
  logic signed [POS_W-1:0] cur_y_next;
  logic [COLOR_W-1:0]      color_next;

  esc_mode_t               mode0;
  logic [3:0]              tens0;
  logic signed [POS_W-1:0] x0;
  logic signed [POS_W-1:0] y0;
  logic signed [POS_W-1:0] line0;
  logic [COLOR_W-1:0]      color0;

  logic    is_digit;
  logic    draw;
  logic    err;
  logic    newline;
  logic    set_color;
  logic    in_fire;
  logic    res_valid;
  logic    out_fire;
  logic [7:0] spot;
  result_t res;

  logic    o_valid;
  result_t o_data;
  logic    s_valid;
  result_t s_data;

  function automatic logic signed [POS_W-1:0] sat_step(
    input logic signed [POS_W-1:0] pen,
    input logic [STEP_W-1:0]       step,
    input logic                    down
  );
    logic signed [SUM_W-1:0] a;
    logic signed [SUM_W-1:0] d;
    logic signed [SUM_W-1:0] s;
    logic signed [POS_W-1:0] r;
    a = SUM_W'(pen);
    d = $signed({{(SUM_W - STEP_W){1'b0}}, step});
    s = down ? a - d : a + d;
    // In range exactly when every bit above the result's sign bit matches it.
    if (s[SUM_W-1:POS_W-1] == {(SUM_W - POS_W + 1){s[SUM_W-1]}}) begin
      r = s[POS_W-1:0];
    end else if (s[SUM_W-1]) begin
      r = {1'b1, {(POS_W - 1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_W - 1){1'b1}}};
    end
    return r;
  endfunction

  assign in_fire  = chars.valid && chars.ready;
  assign out_fire = o_valid && glyphs.ready;
  assign chars.ready = !s_valid;
  assign cfg.ready   = 1'b1;

  // A first character starts from the string origin instead of the held state.
  always_comb begin
    mode0  = chars.first_char ? ESC_NONE          : esc_mode;
    tens0  = chars.first_char ? 4'd0              : tens;
    x0     = chars.first_char ? chars.origin_x    : cur_x;
    y0     = chars.first_char ? chars.origin_y    : cur_y;
    line0  = chars.first_char ? chars.origin_x    : line_x;
    color0 = chars.first_char ? chars.start_color : color;
  end

  assign is_digit = chars.char_code >= CHAR_ZERO && chars.char_code <= CHAR_NINE;

  // Escape sequencer: next mode.
  always_comb begin
    esc_mode_next = ESC_NONE;
    unique case (mode0)
      ESC_DOLLAR: begin
        if (chars.char_code != CHAR_DOLLAR && is_digit) begin
          esc_mode_next = ESC_TENS;
        end
      end
      ESC_TENS: esc_mode_next = ESC_NONE;
      default: begin
        if (chars.char_code == CHAR_DOLLAR) begin
          esc_mode_next = ESC_DOLLAR;
        end
      end
    endcase
    // An escape left open by the final character is dropped.
    if (chars.last_char) begin
      esc_mode_next = ESC_NONE;
    end
  end

  // Escape sequencer: actions.
  always_comb begin
    draw      = 1'b0;
    err       = 1'b0;
    newline   = 1'b0;
    set_color = 1'b0;
    tens_next = tens0;
    unique case (mode0)
      ESC_DOLLAR: begin
        if (chars.char_code == CHAR_DOLLAR) begin
          draw = 1'b1;
        end else if (is_digit) begin
          tens_next = chars.char_code[3:0];
          err       = chars.last_char;
        end else begin
          err = 1'b1;
        end
      end
      ESC_TENS: begin
        if (is_digit) begin
          set_color = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        if (chars.char_code == CHAR_DOLLAR) begin
          err = chars.last_char;
        end else if (chars.char_code == CHAR_NL) begin
          newline = 1'b1;
        end else begin
          draw = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    cur_x_next = x0;
    cur_y_next = y0;
    if (newline) begin
      cur_x_next = line0;
      cur_y_next = sat_step(y0, step_y, 1'b1);
    end else if (draw) begin
      cur_x_next = sat_step(x0, step_x, 1'b0);
    end
    color_next = set_color ? palette_color(tens0, chars.char_code[3:0]) : color0;
  end

  assign spot      = glyph_cell(chars.char_code);
  assign res_valid = in_fire && (draw || err);

  always_comb begin
    res = '0;
    if (err) begin
      res.escape_error = 1'b1;
    end else begin
      res.glyph_col   = spot[7:4];
      res.glyph_row   = spot[3:0];
      res.pen_x       = x0;
      res.pen_y       = y0;
      res.glyph_color = color0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x <= STEP_RESET;
      step_y <= STEP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_SCALE_X: step_x <= STEP_W'(cfg.data) * STEP_W'(GLYPH_PIXELS);
        REG_SCALE_Y: step_y <= STEP_W'(cfg.data) * STEP_W'(GLYPH_PIXELS);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_mode <= ESC_NONE;
      tens     <= 4'd0;
      cur_x    <= '0;
      cur_y    <= '0;
      line_x   <= '0;
      color    <= COLOR_WHITE;
    end else if (in_fire) begin
      esc_mode <= esc_mode_next;
      tens     <= tens_next;
      cur_x    <= cur_x_next;
      cur_y    <= cur_y_next;
      line_x   <= line0;
      color    <= color_next;
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (!o_valid || out_fire) begin
      if (s_valid) begin
        o_valid <= 1'b1;
        s_valid <= res_valid;
      end else begin
        o_valid <= res_valid;
      end
    end else if (res_valid) begin
      s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || out_fire) begin
      o_data <= s_valid ? s_data : res;
      s_data <= res;
    end else if (res_valid) begin
      s_data <= res;
    end
  end

  assign glyphs.valid        = o_valid;
  assign glyphs.glyph_col    = o_data.glyph_col;
  assign glyphs.glyph_row    = o_data.glyph_row;
  assign glyphs.pen_x        = o_data.pen_x;
  assign glyphs.pen_y        = o_data.pen_y;
  assign glyphs.glyph_color  = o_data.glyph_color;
  assign glyphs.escape_error = o_data.escape_error;

  `GTL_ASSERT_NOW(a_skid_behind_result, s_valid, o_valid, "skid entry full while result empty")
  `GTL_ASSERT_NOW(a_error_fields_zero, glyphs.valid && glyphs.escape_error,
    glyphs.pen_x == '0 && glyphs.pen_y == '0 && glyphs.glyph_color == '0,
    "error result carries glyph data")
  `GTL_ASSERT_NEXT(a_last_closes_escape, in_fire && chars.last_char,
    esc_mode == ESC_NONE, "escape still open after last character")
  `GTL_ASSERT_NEXT(a_first_newline_origin,
    in_fire && chars.first_char && chars.char_code == CHAR_NL,
    cur_x == $past(chars.origin_x), "newline on first character missed origin")

endmodule

`default_nettype wire
